[src/slcfr_pkg.sv]
// Shared types and constants for the start/id/length/payload/sum-8 frame receiver.
// Holds the controller state encoding and the command/status bundles.
// No dependencies.
`default_nettype none

package slcfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_PAYLOAD = 16;
    localparam int LEN_W       = 5;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int TDATA_W     = 32;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;

    // One-hot controller states
    typedef enum logic [6:0] {
        ST_HUNT    = 7'b0000001,
        ST_ID      = 7'b0000010,
        ST_LEN     = 7'b0000100,
        ST_DATA    = 7'b0001000,
        ST_CHK     = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_WR = 7'b1000000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic ld_id;
        logic ld_len;
        logic ld_data;
        logic clr_idx;
        logic rd_issue;
        logic out_load;
        logic idx_adv;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_hit;
        logic len_over;
        logic len_zero;
        logic data_done;
        logic sum_match;
        logic out_free;
        logic emit_last;
    } dp_status_t;

endpackage

`default_nettype wire

[src/slcfr_ctrl.sv]
// Frame parse and readout controller.
// Walks hunt/id/length/payload/checksum phases, then sequences the payload readout.
// Depends on slcfr_pkg.
`default_nettype none

module slcfr_ctrl
    import slcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take input beats in every parse phase, stall during readout
    always_comb
    begin
        in_ready = (state_reg == ST_HUNT) || (state_reg == ST_ID) ||
                   (state_reg == ST_LEN) || (state_reg == ST_DATA) ||
                   (state_reg == ST_CHK);
    end

    assign accept = in_valid && in_ready;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HUNT:
            begin
                if (accept && status.start_hit)
                begin
                    state_next = ST_ID;
                end
            end
            ST_ID:
            begin
                if (accept)
                begin
                    cmd.ld_id  = 1'b1;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (accept)
                begin
                    if (status.len_over)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cmd.ld_len = 1'b1;
                        state_next = status.len_zero ? ST_CHK : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (accept)
                begin
                    cmd.ld_data = 1'b1;
                    if (status.data_done)
                    begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                if (accept)
                begin
                    cmd.clr_idx = 1'b1;
                    state_next  = status.sum_match ? ST_EMIT_RD : ST_HUNT;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                // Hold the read byte until the output register frees up
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cmd.idx_adv = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[src/slcfr_dp.sv]
// Frame receiver datapath: header registers, running sum, payload store,
// readout index and the output register. Depends on slcfr_pkg.
`default_nettype none

module slcfr_dp
    import slcfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [BYTE_W-1:0] cfg_wr_data,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [BYTE_W-1:0]      frame_id,
    output logic [LEN_W-1:0]       frame_len,
    output logic                   has_payload,
    output logic [IDX_W-1:0]       byte_index,
    output logic [BYTE_W-1:0]      payload_byte,
    output logic                   last
);

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] held_id_reg;
    logic [LEN_W-1:0]  held_len_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] store [MAX_PAYLOAD];

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_id_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_has_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              len_nonzero;

    assign count_next  = count_reg + LEN_W'(1);
    assign sum_next    = sum_reg + rx_byte;
    assign len_nonzero = (held_len_reg != '0);

    // Status back to the controller
    always_comb
    begin
        status.start_hit = (rx_byte == start_byte_reg);
        status.len_over  = (rx_byte > BYTE_W'(MAX_PAYLOAD));
        status.len_zero  = (rx_byte == '0);
        status.data_done = (count_next >= held_len_reg);
        status.sum_match = (sum_reg == rx_byte);
        status.out_free  = !out_valid_reg || out_ready;
        status.emit_last = !len_nonzero ||
                           ((LEN_W'(idx_reg) + LEN_W'(1)) == held_len_reg);
    end

    // Start byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
        end
        else if (cfg_wr_en)
        begin
            start_byte_reg <= cfg_wr_data;
        end
    end

    // Header, running sum, fill count and readout index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_id_reg  <= '0;
            held_len_reg <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cmd.ld_id)
            begin
                held_id_reg <= rx_byte;
                sum_reg     <= rx_byte;
            end
            if (cmd.ld_len)
            begin
                held_len_reg <= rx_byte[LEN_W-1:0];
                sum_reg      <= sum_next;
                count_reg    <= '0;
            end
            if (cmd.ld_data)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
            if (cmd.clr_idx)
            begin
                count_reg <= '0;
                idx_reg   <= '0;
            end
            if (cmd.idx_adv)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // Payload store: write during the payload phase, registered read during readout
    always_ff @(posedge clk)
    begin
        if (cmd.ld_data)
        begin
            store[count_reg[IDX_W-1:0]] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store[idx_reg];
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_id_reg   <= held_id_reg;
            out_len_reg  <= held_len_reg;
            out_has_reg  <= len_nonzero;
            out_idx_reg  <= idx_reg;
            out_byte_reg <= len_nonzero ? rd_data_reg : '0;
            out_last_reg <= status.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_id     = out_id_reg;
    assign frame_len    = out_len_reg;
    assign has_payload  = out_has_reg;
    assign byte_index   = out_idx_reg;
    assign payload_byte = out_byte_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

[src/sof_len_checksum_frame_receiver_top.sv]
// Frame receiver top: start byte, id, length, up to 16 payload bytes, sum-8 checksum.
// Parse: one input beat per cycle outside readout; a matching checksum beat starts a readout
// of each result (store read, then output register).
// Input stalls for the readout, plus any wait on m_axis_tready.
// Reset (rst_n, async low) returns to hunting, start byte 0xAA; payload store undefined.
// Depends on slcfr_pkg, slcfr_ctrl and slcfr_dp.
`default_nettype none

module sof_len_checksum_frame_receiver_top
    import slcfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [BYTE_W-1:0]  cfg_wr_data,    // start_byte
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [7:0] frame_id, [12:8] frame_len, [16:13] byte_index, [24:17] payload_byte, rest 0
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic                    m_axis_tuser,   // [0] has_payload
    output logic                    m_axis_tlast    // last
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [BYTE_W-1:0] frame_id;
    logic [LEN_W-1:0]  frame_len;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] payload_byte;

    slcfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    slcfr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .rx_byte      (s_axis_tdata),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .frame_id     (frame_id),
        .frame_len    (frame_len),
        .has_payload  (m_axis_tuser),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .last         (m_axis_tlast)
    );

    // Pack the result beat, zero fill to whole bytes
    assign m_axis_tdata = TDATA_W'({payload_byte, byte_index, frame_len, frame_id});

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register loaded while occupied");

    // Input is stalled while the store is being read out
    a_stall_readout: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> !s_axis_tready)
        else $error("input taken during readout");

    // At most one parse action per input beat
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ld_id, cmd.ld_len, cmd.ld_data, cmd.clr_idx, cmd.rd_issue}))
        else $error("conflicting datapath commands");

    // Store reads are never issued back to back
    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> !cmd.rd_issue)
        else $error("back to back store reads");

endmodule

`default_nettype wire
